// ===== rtl/rounded_euclidean_distance_defines.svh =====
// Assertion macros shared by the rounded Euclidean distance checker.
`ifndef ROUNDED_EUCLIDEAN_DISTANCE_DEFINES_SVH
`define ROUNDED_EUCLIDEAN_DISTANCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RED_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rounded_euclidean_distance: check failed");

// Next-cycle implication, disabled while reset is low.
`define RED_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rounded_euclidean_distance: check failed");

`endif

// ===== rtl/red_pkg.sv =====
// Widths, constants and the square-root chain data type.
package red_pkg;

  localparam int COORD_W       = 24;
  localparam int DIFF_W        = 24;            // |a - b| < 2^24
  localparam int SQ_W          = 2 * DIFF_W;
  localparam int SUM_W         = SQ_W + 1;
  localparam int RAD_W         = 52;            // 4*sum, padded to an even width
  localparam int ROOT_W        = RAD_W / 2;
  localparam int REM_W         = ROOT_W + 2;
  localparam int DIST_W        = 21;
  localparam int FRAC_BITS_DEF = 4;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;   // radicand bits not yet consumed, MSB first
    logic [REM_W-1:0]  rem;   // partial remainder
    logic [ROOT_W-1:0] root;  // partial root
  } sqrt_data_t;

endpackage

// ===== rtl/rounded_euclidean_distance.sv =====
// Rounded EUC_2D distance: front end, square-root cell chain, rounding stage.
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------
//   in      | input     | in_valid, in_ready, in_first_x/y, in_second_x/y
//   out     | output    | out_valid, out_ready, out_distance
//
// One request enters per cycle while in_ready is high; out_ready backpressure can drop it.
// Each request passes the front end, the 26-cell root chain (one root bit per cell) and rounding.
// Synchronous active-low reset empties every stage; no data is cleared.
// Each stage loads when empty or moving, so bubbles close up under a stall
// and in_ready stays high while any stage along the path is free.
module rounded_euclidean_distance #(
  parameter int FRAC_BITS = red_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [red_pkg::COORD_W-1:0] in_first_x,
  input  logic signed [red_pkg::COORD_W-1:0] in_first_y,
  input  logic signed [red_pkg::COORD_W-1:0] in_second_x,
  input  logic signed [red_pkg::COORD_W-1:0] in_second_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [red_pkg::DIST_W-1:0]         out_distance
);
  import red_pkg::*;

  sqrt_data_t cd [0:ROOT_W];
  logic       cv [0:ROOT_W];
  logic       cr [0:ROOT_W];

  red_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .second_x (in_second_x),
    .second_y (in_second_y),
    .dn_valid (cv[0]),
    .dn_ready (cr[0]),
    .dn_data  (cd[0])
  );

  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    red_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[k]),
      .up_ready (cr[k]),
      .up_data  (cd[k]),
      .dn_valid (cv[k+1]),
      .dn_ready (cr[k+1]),
      .dn_data  (cd[k+1])
    );
  end

  red_round #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (cv[ROOT_W]),
    .up_ready     (cr[ROOT_W]),
    .root         (cd[ROOT_W].root),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_distance (out_distance)
  );

endmodule

// ===== rtl/red_front.sv =====
// Front end: coordinate differences, squares and the radicand sum.
module red_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [red_pkg::COORD_W-1:0] first_x,
  input  logic signed [red_pkg::COORD_W-1:0] first_y,
  input  logic signed [red_pkg::COORD_W-1:0] second_x,
  input  logic signed [red_pkg::COORD_W-1:0] second_y,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output red_pkg::sqrt_data_t                dn_data
);
  import red_pkg::*;

  logic                v1_r, v2_r, v3_r;
  logic [DIFF_W-1:0]   dx_r, dy_r;
  logic [SQ_W-1:0]     sqx_r, sqy_r;
  sqrt_data_t          rad_r;

  logic                rdy1, rdy2, rdy3;
  logic signed [COORD_W:0] ddx, ddy;
  logic [DIFF_W-1:0]   dx_nxt, dy_nxt;
  logic [SUM_W-1:0]    sum_nxt;
  sqrt_data_t          rad_nxt;

  // a stage may load when it is empty or its contents move on
  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    ddx    = {second_x[COORD_W-1], second_x} - {first_x[COORD_W-1], first_x};
    ddy    = {second_y[COORD_W-1], second_y} - {first_y[COORD_W-1], first_y};
    dx_nxt = ddx[COORD_W] ? DIFF_W'(-ddx) : DIFF_W'(ddx);
    dy_nxt = ddy[COORD_W] ? DIFF_W'(-ddy) : DIFF_W'(ddy);
    sum_nxt = SUM_W'(sqx_r) + SUM_W'(sqy_r);
    rad_nxt.rad  = {{(RAD_W - SUM_W - 2){1'b0}}, sum_nxt, 2'b00};
    rad_nxt.rem  = '0;
    rad_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (rdy2 && v1_r) begin
      sqx_r <= dx_r * dx_r;
      sqy_r <= dy_r * dy_r;
    end
    if (rdy3 && v2_r) begin
      rad_r <= rad_nxt;
    end
  end

  assign dn_valid = v3_r;
  assign dn_data  = rad_r;

endmodule

// ===== rtl/red_sqrt_cell.sv =====
// One restoring square-root cell: settles one root bit per request.
module red_sqrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  red_pkg::sqrt_data_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output red_pkg::sqrt_data_t dn_data
);
  import red_pkg::*;

  logic             vld_r;
  sqrt_data_t       data_r;
  sqrt_data_t       data_nxt;
  logic [REM_W-1:0] rem_sh, trial;
  logic             take;

  assign up_ready = !vld_r || dn_ready;

  always_comb begin
    rem_sh = {up_data.rem[REM_W-3:0], up_data.rad[RAD_W-1:RAD_W-2]};
    trial  = {up_data.root, 2'b01};
    take   = rem_sh >= trial;
    data_nxt.rem  = take ? rem_sh - trial : rem_sh;
    data_nxt.root = {up_data.root[ROOT_W-2:0], take};
    data_nxt.rad  = {up_data.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) data_r <= data_nxt;
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/red_round.sv =====
// Output stage: drops fraction bits, rounds half up, saturates, holds result.
module red_round #(
  parameter int FRAC_BITS = red_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic [red_pkg::ROOT_W-1:0]   root,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [red_pkg::DIST_W-1:0]   out_distance
);
  import red_pkg::*;

  localparam int Q_W   = ROOT_W - FRAC_BITS;
  localparam int CMP_W = (Q_W > DIST_W) ? Q_W : DIST_W;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  logic              vld_r;
  logic [DIST_W-1:0] dist_r;

  logic [Q_W-1:0]    q;
  logic [Q_W:0]      q_inc;
  logic [Q_W-1:0]    d_full;
  logic [DIST_W-1:0] dist_nxt;

  assign up_ready = !vld_r || out_ready;

  // root is isqrt(4*S); (q + 1) >> 1 rounds sqrt(S) / 2^FRAC_BITS half up
  always_comb begin
    q        = root[ROOT_W-1:FRAC_BITS];
    q_inc    = {1'b0, q} + (Q_W+1)'(1);
    d_full   = q_inc[Q_W:1];
    dist_nxt = (CMP_W'(d_full) > CMP_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(d_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) dist_r <= dist_nxt;
  end

  assign out_valid    = vld_r;
  assign out_distance = dist_r;

endmodule

// ===== rtl/red_checker.sv =====
// Port-level checks for the rounded Euclidean distance block, bound to the top.
`include "rounded_euclidean_distance_defines.svh"

module red_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [red_pkg::DIST_W-1:0] out_distance
);
  import red_pkg::*;

  // a held result keeps its request and value
  `RED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `RED_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_distance))
  // nothing comes out right after reset
  `RED_ASSERT_NOW(a_reset_empty, clk, rst_n, !$past(rst_n), !out_valid)
  // an empty output stage lets every upstream stage move
  `RED_ASSERT_NOW(a_ready_free, clk, rst_n, !out_valid, in_ready)

endmodule

bind rounded_euclidean_distance red_checker u_red_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the rounded EUC_2D distance pipeline.
module tb_top;
  import red_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_PAIRS   = 1750;
  localparam int HOLD_CYCLES    = 250;
  localparam int C_MIN          = -8388608;
  localparam int C_MAX          = 8388607;
  localparam int C_SPAN         = 16777215;

  typedef struct {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } city_pair_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_first_x = '0;
  logic signed [COORD_W-1:0] in_first_y = '0;
  logic signed [COORD_W-1:0] in_second_x = '0;
  logic signed [COORD_W-1:0] in_second_y = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [DIST_W-1:0]         out_distance;

  city_pair_t        pending_pairs[$];
  logic [DIST_W-1:0] expected_dist[$];
  city_pair_t        next_pair;
  int                errors = 0;
  int                offered = 0;
  int                taken = 0;
  int                hold_left = 0;
  bit                hold_done = 1'b0;

  rounded_euclidean_distance u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_first_x  (in_first_x),
    .in_first_y  (in_first_y),
    .in_second_x (in_second_x),
    .in_second_y (in_second_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_distance(out_distance)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Exact rounded distance: floor(sqrt(4*S)) >> FRAC, then round half up.
  function automatic logic [DIST_W-1:0] euc2d_distance(city_pair_t p);
    longint          dx;
    longint          dy;
    longint unsigned rad;
    longint unsigned root;
    longint unsigned trial;
    longint unsigned d;
    int              b;
    dx = longint'(p.bx) - longint'(p.ax);
    dy = longint'(p.by) - longint'(p.ay);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    rad = longint'(dx * dx + dy * dy) << 2;
    root = 0;
    for (b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= rad) root = trial;
    end
    d = ((root >> FRAC_BITS_DEF) + 1) >> 1;
    if (d > (64'd1 << DIST_W) - 1) d = (64'd1 << DIST_W) - 1;
    return d[DIST_W-1:0];
  endfunction

  function automatic city_pair_t mk_pair(int ax, int ay, int bx, int by);
    city_pair_t p;
    p.ax = COORD_W'(ax);
    p.ay = COORD_W'(ay);
    p.bx = COORD_W'(bx);
    p.by = COORD_W'(by);
    return p;
  endfunction

  function automatic void add_pair(city_pair_t p);
    pending_pairs = {pending_pairs, p};
  endfunction

  // Start point such that start + len stays in the coordinate range.
  function automatic int span_base(int len);
    return C_MIN + int'($urandom_range(C_SPAN - len, 0));
  endfunction

  function automatic int pick_corner();
    case ($urandom_range(4, 0))
      0: return C_MIN;
      1: return C_MAX;
      2: return 0;
      3: return -1;
      default: return int'($signed($urandom() & 32'h00ffffff) <<< 8) >>> 8;
    endcase
  endfunction

  function automatic city_pair_t random_pair();
    city_pair_t p;
    int         kind;
    int         n;
    int         m;
    int         bx0;
    int         by0;
    kind = $urandom_range(99, 0);
    p.ax = COORD_W'($urandom());
    p.ay = COORD_W'($urandom());
    p.bx = COORD_W'($urandom());
    p.by = COORD_W'($urandom());
    if (kind < 35) begin
      // fully random coordinates
    end else if (kind < 60) begin
      p.bx = p.ax + COORD_W'(int'($urandom_range(4096, 0)) - 2048);
      p.by = p.ay + COORD_W'(int'($urandom_range(4096, 0)) - 2048);
    end else if (kind < 68) begin
      // axis-aligned exact half: 16n + 8 sixteenths
      n = $urandom_range(524000, 0);
      m = 16 * n + 8;
      bx0 = span_base(m);
      if ($urandom_range(1, 0)) p = mk_pair(bx0, int'(p.ay), bx0 + m, int'(p.ay));
      else p = mk_pair(int'(p.ax), bx0, int'(p.ax), bx0 + m);
    end else if (kind < 76) begin
      // 3-4-5 triangle with hypotenuse 5n + 5/2 units, an exact half
      n = $urandom_range(100000, 0);
      m = 16 * n + 8;
      bx0 = span_base(3 * m);
      by0 = span_base(4 * m);
      p = mk_pair(bx0, by0, bx0 + 3 * m, by0 + 4 * m);
    end else if (kind < 85) begin
      p.bx = p.ax;
      if ($urandom_range(1, 0)) p.by = p.ay;
    end else begin
      p = mk_pair(pick_corner(), pick_corner(), pick_corner(), pick_corner());
    end
    if ($urandom_range(1, 0)) p = mk_pair(int'(p.bx), int'(p.by), int'(p.ax), int'(p.ay));
    return p;
  endfunction

  task automatic report(string what, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
    $display("MISMATCH at %0t: %s: expected %0d, got %0d", $time, what, want, got);
    errors++;
  endtask

  // Driver: may offer the next pair once the current one is taken or none is up.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_pairs.size() != 0 &&
          ((offered >= 800 && offered < 1100) || $urandom_range(99, 0) >= 7)) begin
        next_pair = pending_pairs.pop_front();
        in_first_x  <= next_pair.ax;
        in_first_y  <= next_pair.ay;
        in_second_x <= next_pair.bx;
        in_second_y <= next_pair.by;
        in_valid    <= 1'b1;
        offered     <= offered + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random backpressure, one long hold-off to fill the pipe.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && taken >= 300) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (taken >= 800 && taken < 1100) || ($urandom_range(99, 0) >= 7);
    end
  end

  // Monitor: check results first, then log the request taken on this edge.
  always @(posedge clk) begin : monitor
    logic [DIST_W-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        taken <= taken + 1;
        if (expected_dist.size() == 0) begin
          report("result with no request pending", '0, out_distance);
        end else begin
          want = expected_dist.pop_front();
          if (out_distance !== want) report("distance", want, out_distance);
        end
      end
      if (in_valid && in_ready)
        expected_dist = {expected_dist, euc2d_distance(
          mk_pair(int'(in_first_x), int'(in_first_y), int'(in_second_x), int'(in_second_y)))};
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall = 0;
      else stall++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int i;
    // identical cities
    add_pair(mk_pair(0, 0, 0, 0));
    add_pair(mk_pair(C_MIN, C_MAX, C_MIN, C_MAX));
    add_pair(mk_pair(-1, -1, -1, -1));
    // widest spans
    add_pair(mk_pair(C_MIN, C_MIN, C_MAX, C_MAX));
    add_pair(mk_pair(C_MAX, C_MAX, C_MIN, C_MIN));
    add_pair(mk_pair(C_MIN, C_MAX, C_MAX, C_MIN));
    add_pair(mk_pair(C_MIN, 0, C_MAX, 0));
    add_pair(mk_pair(0, C_MAX, 0, C_MIN));
    // exact halves round up
    add_pair(mk_pair(0, 0, 8, 0));
    add_pair(mk_pair(0, 0, 0, -24));
    add_pair(mk_pair(-10, -20, 14, 12));
    add_pair(mk_pair(-8000000, 5, 8000008, 5));
    // just below and just above a half, and a short diagonal
    add_pair(mk_pair(0, 0, 7, 3));
    add_pair(mk_pair(0, 0, 8, 1));
    add_pair(mk_pair(-1, -1, 0, 0));
    // a whole distance and a wide diagonal
    add_pair(mk_pair(100, -100, 148, -36));
    add_pair(mk_pair(C_MAX, -1, 0, C_MIN));
    for (i = 0; i < RANDOM_PAIRS; i++) add_pair(random_pair());

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || in_valid) @(posedge clk);
    while (expected_dist.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/red_pkg.sv
rtl/red_front.sv
rtl/red_sqrt_cell.sv
rtl/red_round.sv
rtl/rounded_euclidean_distance.sv
rtl/red_checker.sv
test/tb_top.sv
